/* rtl/rmst_pkg.sv */
`default_nettype none

package rmst_pkg;

  localparam int LEAF_COUNT = 1024;
  localparam int LEAF_AW    = $clog2(LEAF_COUNT);
  localparam int NODE_AW    = LEAF_AW + 1;
  localparam int NODE_COUNT = 2 * LEAF_COUNT;
  localparam int PTR_W      = NODE_AW + 1;
  localparam int CNT_W      = LEAF_AW + 1;
  localparam int VAL_W      = 32;

  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QLO,
    ST_QHI,
    ST_QFIN
  } rmst_state_t;

endpackage

`default_nettype wire

/* rtl/rmst_req_if.sv */
`default_nettype none

interface rmst_req_if
  import rmst_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [LEAF_AW-1:0]      update_index;
  logic signed [VAL_W-1:0] update_value;
  logic [LEAF_AW-1:0]      query_first;
  logic [LEAF_AW-1:0]      query_last;

  modport source (output valid, opcode, update_index, update_value, query_first, query_last,
                  input ready);
  modport sink   (input valid, opcode, update_index, update_value, query_first, query_last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/rmst_rsp_if.sv */
`default_nettype none

interface rmst_rsp_if
  import rmst_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] range_minimum;

  modport source (output valid, range_minimum, input ready);
  modport sink   (input valid, range_minimum, output ready);
endinterface

`default_nettype wire

/* rtl/rmst_ram.sv */
`default_nettype none

module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/range_min_segment_tree.sv */
`default_nettype none

// Channel   Dir  Ports                     Carries
// in_req    in   valid/ready + payload     update (index, value) or range query
// out_rsp   out  valid/ready + payload     range minimum, one per query request
// cfg       in   cfg_we, cfg_wdata         active_count, write only
//
// Steps: update = leaf write on accept, then one tree level per cycle up to the root;
//   query = ST_QLO and ST_QHI in turn per tree level walked, then ST_QLO exit check and
//   ST_QFIN; the single read port of the node RAM sets this (two candidate reads per
//   level). A dropped update stays in ST_IDLE, an empty query goes straight to ST_QFIN.
// Reset: after rst_n the node RAM is swept to INT_MAX, one entry per cycle,
//   over all NODE_COUNT entries with in_req.ready low; cfg writes are taken meanwhile.
// Stalls: the result sits in an output register, so a new request is taken while
//   it waits; a finished query waits in ST_QFIN only if that register is full.

module range_min_segment_tree
  import rmst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  rmst_req_if.sink         in_req,
  rmst_rsp_if.source       out_rsp,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  rmst_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        active_count_r;
  logic [NODE_AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [NODE_AW-1:0]      pos_r, pos_nxt;         // update: node just written
  logic signed [VAL_W-1:0] val_r, val_nxt;         // update: running path minimum
  logic [PTR_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic                    rd_pend_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_min_r, out_min_nxt;

  // node RAM port
  logic               ram_we, ram_re;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]   ram_wdata, ram_rdata;
  logic signed [VAL_W-1:0] rd_val;

  rmst_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val = $signed(ram_rdata);

  // request decode, all done in the accept cycle
  logic               acc;
  logic [CNT_W-1:0]   eff_cnt;
  logic               upd_ok;
  logic [CNT_W-1:0]   q_first, q_last, last_clip;
  logic               q_empty;
  logic [NODE_AW-1:0] leaf_addr;
  logic               clr_done;

  assign in_req.ready = (state_r == ST_IDLE);
  assign acc          = in_req.valid && in_req.ready;

  // count above the leaf total acts as the leaf total
  assign eff_cnt   = (active_count_r > CNT_W'(LEAF_COUNT)) ? CNT_W'(LEAF_COUNT)
                                                           : active_count_r;
  assign upd_ok    = {1'b0, in_req.update_index} < eff_cnt;
  assign q_first   = {1'b0, in_req.query_first};
  assign q_last    = {1'b0, in_req.query_last};
  assign last_clip = (q_last >= eff_cnt) ? eff_cnt - CNT_W'(1) : q_last;
  // zero count, start past the count, or start past the clipped end
  assign q_empty   = (eff_cnt == '0) || (q_first >= eff_cnt) || (q_first > last_clip);
  assign leaf_addr = NODE_AW'(LEAF_COUNT) + NODE_AW'(in_req.update_index);
  assign clr_done  = (clr_cnt_r == NODE_AW'(NODE_COUNT - 1));

  // update walk: parent of the node written last
  logic [NODE_AW-1:0] par;
  assign par = pos_r >> 1;

  // query walk helpers
  logic [PTR_W-1:0]        hi_dec;
  logic signed [VAL_W-1:0] best_fold;
  logic                    out_free;

  assign hi_dec    = hi_r[0] ? hi_r - PTR_W'(1) : hi_r;
  assign best_fold = (rd_pend_r && (rd_val < best_r)) ? rd_val : best_r;
  assign out_free  = !out_valid_r || out_rsp.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_req.opcode == OP_QUERY) begin
            state_nxt = q_empty ? ST_QFIN : ST_QLO;
          end else if (upd_ok) begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (par == NODE_AW'(1)) state_nxt = ST_IDLE;
      end
      ST_QLO: begin
        state_nxt = (lo_r < hi_r) ? ST_QHI : ST_QFIN;
      end
      ST_QHI: begin
        state_nxt = ST_QLO;
      end
      ST_QFIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    clr_cnt_nxt   = clr_cnt_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_min_nxt   = out_min_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = INT_MAX;
        clr_cnt_nxt = clr_cnt_r + NODE_AW'(1);
      end
      ST_IDLE: begin
        if (acc && in_req.opcode == OP_UPDATE && upd_ok) begin
          // write the leaf, fetch its sibling for the first level
          ram_we    = 1'b1;
          ram_waddr = leaf_addr;
          ram_wdata = in_req.update_value;
          ram_re    = 1'b1;
          ram_raddr = leaf_addr ^ NODE_AW'(1);
          pos_nxt   = leaf_addr;
          val_nxt   = in_req.update_value;
        end
        if (acc && in_req.opcode == OP_QUERY) begin
          best_nxt = INT_MAX;
          lo_nxt   = PTR_W'(LEAF_COUNT) + PTR_W'(q_first);
          hi_nxt   = PTR_W'(LEAF_COUNT) + PTR_W'(last_clip) + PTR_W'(1);
        end
      end
      ST_UPD: begin
        val_nxt   = (rd_val < val_r) ? rd_val : val_r;
        ram_we    = 1'b1;
        ram_waddr = par;
        ram_wdata = val_nxt;
        pos_nxt   = par;
        if (par != NODE_AW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = par ^ NODE_AW'(1);
        end
      end
      ST_QLO: begin
        best_nxt = best_fold;
        if (lo_r < hi_r && lo_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = lo_r[NODE_AW-1:0];
          lo_nxt    = lo_r + PTR_W'(1);
        end
      end
      ST_QHI: begin
        best_nxt = best_fold;
        if (hi_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = hi_dec[NODE_AW-1:0];
        end
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_dec >> 1;
      end
      ST_QFIN: begin
        best_nxt = best_fold;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = best_fold;
        end
      end
      default: begin
        clr_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      active_count_r <= CNT_W'(LEAF_COUNT);
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_pend_r   <= ram_re;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        active_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    best_r    <= best_nxt;
    out_min_r <= out_min_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.range_minimum = out_min_r;

  // same-cycle read and write never hit one entry
  a_no_rw_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("node RAM read and write to the same entry");

  // update walk never sits on the root
  a_upd_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (pos_r > NODE_AW'(1)))
    else $error("update walk past the root");

  // read data is only pending where it gets consumed
  a_pend_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_UPD || state_r == ST_QLO || state_r == ST_QHI))
    else $error("RAM read data dropped");

  // a result only appears out of the finish state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !out_valid_r) |-> (state_r == ST_QFIN))
    else $error("result without a query");

  // no request taken while the clear sweep runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE) && !rd_pend_r)
    else $error("activity during clear sweep");

endmodule

`default_nettype wire

/* tb/range_min_segment_tree_checker.sv */
`timescale 1ns / 100ps

module range_min_segment_tree_checker
  import rmst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  rmst_req_if                   req_mon,
  rmst_rsp_if                   rsp_mon,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    results_pending
);

  // shadow tree: leaves at LEAF_COUNT + i, node k covers 2k and 2k+1
  logic signed [VAL_W-1:0] subtree_min [NODE_COUNT];
  logic [CNT_W-1:0]        active_count;
  logic signed [VAL_W-1:0] expected_minima [$];
  logic signed [VAL_W-1:0] want;
  int                      mismatches = 0;

  function automatic int usable_count();
    return (active_count > CNT_W'(LEAF_COUNT)) ? LEAF_COUNT : int'(active_count);
  endfunction

  function automatic logic signed [VAL_W-1:0] lesser(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic void write_element(input int idx, input logic signed [VAL_W-1:0] value);
    int pos;
    if (idx >= usable_count()) return;
    pos = LEAF_COUNT + idx;
    subtree_min[pos] = value;
    while (pos > 1) begin
      pos = pos / 2;
      subtree_min[pos] = lesser(subtree_min[2*pos], subtree_min[2*pos+1]);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] min_over_range(input int first, input int last);
    int count;
    int top;
    int lo;
    int hi;
    logic signed [VAL_W-1:0] best;
    count = usable_count();
    best  = INT_MAX;
    top   = last;
    if (first >= count) return best;
    if (top >= count) top = count - 1;
    if (first > top) return best;
    lo = LEAF_COUNT + first;
    hi = LEAF_COUNT + top + 1;
    while (lo < hi) begin
      if (lo % 2 == 1) begin
        best = lesser(best, subtree_min[lo]);
        lo++;
      end
      if (hi % 2 == 1) begin
        hi--;
        best = lesser(best, subtree_min[hi]);
      end
      lo = lo / 2;
      hi = hi / 2;
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (subtree_min[k]) subtree_min[k] = INT_MAX;
      active_count = CNT_W'(LEAF_COUNT);
      expected_minima.delete();
    end else begin
      // results first: a query taken on this edge cannot be answered on it
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_minima.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result, range_minimum %0d", $time,
                     rsp_mon.range_minimum);
        end else begin
          want = expected_minima.pop_front();
          if (rsp_mon.range_minimum !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: range_minimum expected %0d, got %0d", $time, want,
                       rsp_mon.range_minimum);
          end
        end
      end
      if (cfg_we) active_count = cfg_wdata;
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.opcode == OP_UPDATE)
          write_element(int'(req_mon.update_index), req_mon.update_value);
        else
          expected_minima.push_back(min_over_range(int'(req_mon.query_first),
                                                   int'(req_mon.query_last)));
      end
    end
    mismatch_count  <= mismatches;
    results_pending <= expected_minima.size();
  end

endmodule

/* tb/range_min_segment_tree_test.sv */
`timescale 1ns / 100ps

module range_min_segment_tree_test;
  import rmst_pkg::*;

  // Quiet cycles tolerated: covers the post-reset sweep with in_req.ready low,
  // a full query walk, plus random stalls on top.
  localparam int WATCHDOG_LIMIT = 6000;
  // Drain margin: an update gives no result but keeps the tree busy up to the root.
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASES         = 8;

  // Random phases: active_count written, requests issued.
  // Counts cover tiny sets, above-leaf value (acts as full), and full tree.
  localparam int PHASE_COUNT [PHASES] = '{16, 1024, 1023, 5, 2047, 300, 1, 1024};
  localparam int PHASE_ITEMS [PHASES] = '{80, 90, 90, 70, 80, 80, 50, 80};

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             result_ready = 1'b0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               quiet_cycles = 0;
  int               cur_count;        // elements in use, capped at LEAF_COUNT
  int               mismatch_count;
  int               results_pending;

  rmst_req_if req_ch ();
  rmst_rsp_if rsp_ch ();

  assign rsp_ch.ready = result_ready;

  range_min_segment_tree u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  range_min_segment_tree_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_mon         (req_ch),
    .rsp_mon         (rsp_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: back-pressure at the percentage of the current phase.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request: random idle cycles first (valid low), then hold until taken.
  // Entered and left right after a rising edge, so valid gets one update per step.
  task automatic send_request(input logic op, input int idx, input int value,
                              input int first, input int last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.update_index <= LEAF_AW'(idx);
    req_ch.update_value <= VAL_W'(value);
    req_ch.query_first  <= LEAF_AW'(first);
    req_ch.query_last   <= LEAF_AW'(last);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Fields an operation does not use carry junk, the block must ignore them.
  task automatic put_update(input int idx, input int value);
    send_request(OP_UPDATE, idx, value, $urandom, $urandom);
  endtask

  task automatic ask_min(input int first, input int last);
    send_request(OP_QUERY, $urandom, $urandom, first, last);
  endtask

  // Wait for every predicted result, then let a trailing update finish.
  // The first edge lets the checker's pending count see the last request.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_count(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_count = (value > LEAF_COUNT) ? LEAF_COUNT : value;
  endtask

  // Extremes show up often so ties and sign handling get exercised.
  function automatic int pick_value();
    case ($urandom_range(15))
      0:       return INT_MAX;
      1:       return 32'sh8000_0000;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range updates and ordered ranges inside the active window;
  // the rest is raw 10-bit noise (dropped updates, clipped or reversed ranges).
  task automatic random_request();
    int a;
    int b;
    int t;
    if ($urandom_range(1) == 1) begin
      if (cur_count == 0 || $urandom_range(9) == 0) a = $urandom_range(LEAF_COUNT - 1);
      else a = $urandom_range(cur_count - 1);
      put_update(a, pick_value());
    end else begin
      if (cur_count == 0 || $urandom_range(6) == 0) begin
        a = $urandom_range(LEAF_COUNT - 1);
        b = $urandom_range(LEAF_COUNT - 1);
      end else begin
        a = $urandom_range(cur_count - 1);
        b = $urandom_range(cur_count - 1);
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
      end
      ask_min(a, b);
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_UPDATE;
    req_ch.update_index <= '0;
    req_ch.update_value <= '0;
    req_ch.query_first  <= '0;
    req_ch.query_last   <= '0;
    cur_count = LEAF_COUNT;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset count (full tree), no idling. Requests wait out the
    // post-reset sweep on in_req.ready.
    put_update(0, 32'sh8000_0000);         // most negative at the first leaf
    put_update(LEAF_COUNT - 1, INT_MAX);   // largest at the last leaf
    put_update(512, -1);
    put_update(511, 0);
    ask_min(0, LEAF_COUNT - 1);            // whole tree
    ask_min(1, LEAF_COUNT - 1);
    ask_min(LEAF_COUNT - 1, LEAF_COUNT - 1);
    ask_min(LEAF_COUNT - 1, 0);            // reversed range: empty
    ask_min(511, 511);                     // single element
    ask_min(513, LEAF_COUNT - 2);          // never written leaves
    put_update(LEAF_COUNT - 1, 5);         // overwrite
    ask_min(600, LEAF_COUNT - 1);
    drain();

    // Count above the leaf total behaves as the full tree.
    write_count(2047);
    put_update(LEAF_COUNT - 1, -100);
    ask_min(1000, LEAF_COUNT - 1);
    ask_min(0, LEAF_COUNT - 1);
    drain();

    // Count of zero: updates dropped, every query empty.
    write_count(0);
    put_update(3, -5);
    ask_min(0, LEAF_COUNT - 1);
    drain();

    // One element: out-of-range update dropped, ranges clipped or empty.
    write_count(1);
    put_update(0, 11);
    put_update(1, -999);
    ask_min(0, LEAF_COUNT - 1);
    ask_min(1, 5);
    drain();

    // Raise the count again: elements hidden meanwhile come back.
    write_count(LEAF_COUNT);
    ask_min(1000, LEAF_COUNT - 1);
    drain();

    // Random phases. Idling rotates: none, sender 51%, receiver 51%, both 6%.
    for (int p = 0; p < PHASES; p++) begin
      write_count(PHASE_COUNT[p]);
      case (p % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 51;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 51;
        end
        default: begin
          send_idle_pct  <= 6;
          recv_stall_pct <= 6;
        end
      endcase
      // Build the front of the array first, one update per element, so
      // queries see real data, then mix updates and queries.
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        if (i < cur_count && i < 24) put_update(i, pick_value());
        else random_request();
      end
      drain();
    end

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
